@@ design/covalent_bond_pair_test_core_assert.svh @@
// ============================================================================
// Covalent bond pair test assertion macros
// Shared concurrent assertion forms for the covalent bond pair test checker.
// ============================================================================
`ifndef COVALENT_BOND_PAIR_TEST_CORE_ASSERT_SVH
`define COVALENT_BOND_PAIR_TEST_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("covalent bond pair test: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define CBPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("covalent bond pair test: next-cycle property failed");

`endif

@@ design/cbpt_pkg.sv @@
// ============================================================================
// Covalent bond pair test package
// Beat types, register indexes, widths and the covalent radius table.
// ============================================================================
package cbpt_pkg;

    localparam int unsigned MAX_ATOMS     = 65536;
    localparam int unsigned ELEMENT_TYPES = 103;

    localparam int INDEX_W = 16;
    localparam int COORD_W = 24;
    localparam int TYPE_W  = 7;
    localparam int SCALE_W = 16;
    localparam int COUNT_W = 17;
    localparam int WDATA_W = 17;
    localparam int WIDX_W  = 2;

    localparam int ABS_W        = 24;
    localparam int SQ_W         = 48;
    localparam int D2_W         = 50;
    localparam int LHS_W        = 64;
    localparam int RAD_W        = 9;
    localparam int SUM_W        = 11;
    localparam int SQR_W        = 21;
    localparam int MSQ_W        = 32;
    localparam int BOND_P_W     = 37;
    localparam int SEARCH_P_W   = 53;
    localparam int BOND_SHIFT   = 10;
    localparam int SEARCH_SHIFT = 2;
    localparam int BOND_RHS_W   = BOND_P_W + BOND_SHIFT;
    localparam int SEARCH_RHS_W = SEARCH_P_W + SEARCH_SHIFT;

    localparam int PIPE_LATENCY = 5;

    localparam logic [SUM_W-1:0]   TOL_UNITS    = 11'd140;
    localparam logic [SUM_W-1:0]   SEARCH_UNITS = 11'd640;
    localparam logic [LHS_W-1:0]   LHS_FACTOR   = 64'd15625;
    localparam logic [TYPE_W-1:0]  HYDROGEN     = 7'd0;
    localparam logic [SCALE_W-1:0] SCALE_RST    = 16'd256;
    localparam logic [COUNT_W-1:0] COUNT_RST    = 17'd0;

    typedef enum logic [WIDX_W-1:0] {
        REG_BOND_SCALE  = 2'd0,
        REG_HBOND_SCALE = 2'd1,
        REG_ATOM_COUNT  = 2'd2
    } cbpt_reg_idx_t;

    typedef struct packed {
        logic        [INDEX_W-1:0] first_index;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic        [TYPE_W-1:0]  first_type;
        logic        [INDEX_W-1:0] second_index;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic        [TYPE_W-1:0]  second_type;
    } cbpt_pair_t;

    typedef struct packed {
        logic is_bond;
        logic used_hydrogen_scale;
        logic in_search_radius;
    } cbpt_result_t;

    typedef struct packed {
        logic [SCALE_W-1:0] bond_scale;
        logic [SCALE_W-1:0] hbond_scale;
        logic [COUNT_W-1:0] atom_count;
    } cbpt_cfg_t;

    typedef struct packed {
        logic                    valid;
        logic                    idx_ok;
        logic                    one_h;
        logic                    both_h;
        logic [BOND_RHS_W-1:0]   bond_rhs;
        logic [SEARCH_RHS_W-1:0] search_rhs;
    } cbpt_bound_t;

    // Covalent radii in 1/250 angstrom; entries past the last element read zero.
    localparam logic [RAD_W-1:0] COV_ROM [128] = '{
        9'd80,  9'd400, 9'd170, 9'd88,  9'd208, 9'd180, 9'd170, 9'd170, 9'd160, 9'd280,
        9'd243, 9'd275, 9'd338, 9'd300, 9'd259, 9'd255, 9'd250, 9'd392, 9'd332, 9'd248,
        9'd360, 9'd368, 9'd332, 9'd338, 9'd338, 9'd335, 9'd332, 9'd405, 9'd380, 9'd362,
        9'd305, 9'd292, 9'd302, 9'd305, 9'd302, 9'd400, 9'd368, 9'd280, 9'd445, 9'd390,
        9'd370, 9'd368, 9'd338, 9'd350, 9'd362, 9'd375, 9'd398, 9'd422, 9'd408, 9'd365,
        9'd365, 9'd368, 9'd350, 9'd425, 9'd418, 9'd335, 9'd468, 9'd458, 9'd455, 9'd452,
        9'd450, 9'd450, 9'd498, 9'd448, 9'd440, 9'd438, 9'd435, 9'd432, 9'd430, 9'd485,
        9'd430, 9'd392, 9'd358, 9'd342, 9'd338, 9'd342, 9'd330, 9'd375, 9'd375, 9'd425,
        9'd388, 9'd385, 9'd385, 9'd420, 9'd302, 9'd475, 9'd450, 9'd358, 9'd295, 9'd255,
        9'd222, 9'd242, 9'd238, 9'd232, 9'd230, 9'd228, 9'd225, 9'd222, 9'd220, 9'd218,
        9'd215, 9'd212, 9'd210, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,
        9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,
        9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0
    };

    function automatic logic [RAD_W-1:0] cov_radius(input logic [TYPE_W-1:0] t);
        logic [RAD_W-1:0] r;
        if (32'(t) >= ELEMENT_TYPES)
        begin
            r = '0;
        end
        else
        begin
            r = COV_ROM[t];
        end
        return r;
    endfunction

endpackage

@@ design/cbpt_cfg_regs.sv @@
// ============================================================================
// Covalent bond pair test configuration registers
// Holds the two distance scales and the atom count behind a plain write port.
// ============================================================================
module cbpt_cfg_regs
    import cbpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [WIDX_W-1:0]  wr_index,
    input  logic [WDATA_W-1:0] wr_data,
    output cbpt_cfg_t          cfg
);

    cbpt_cfg_t cfg_reg;
    cbpt_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cbpt_reg_idx_t'(wr_index))
                REG_BOND_SCALE:  cfg_next.bond_scale  = wr_data[SCALE_W-1:0];
                REG_HBOND_SCALE: cfg_next.hbond_scale = wr_data[SCALE_W-1:0];
                REG_ATOM_COUNT:  cfg_next.atom_count  = wr_data[COUNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bond_scale  <= SCALE_RST;
            cfg_reg.hbond_scale <= SCALE_RST;
            cfg_reg.atom_count  <= COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/cbpt_dist_pipe.sv @@
// ============================================================================
// Covalent bond pair test distance pipeline
// Four stages: absolute differences, squares, sum, and scaling of the
// squared distance by 15625.
// ============================================================================
module cbpt_dist_pipe
    import cbpt_pkg::*;
(
    input  logic             clk,
    input  cbpt_pair_t       pair,
    output logic [LHS_W-1:0] lhs
);

    logic [ABS_W-1:0] absd_reg [3];
    logic [ABS_W-1:0] absd_next [3];
    logic [SQ_W-1:0]  sq_reg [3];
    logic [SQ_W-1:0]  sq_next [3];
    logic [D2_W-1:0]  d2_reg;
    logic [D2_W-1:0]  d2_next;
    logic [LHS_W-1:0] lhs_reg;
    logic [LHS_W-1:0] lhs_next;

    logic signed [COORD_W-1:0] a_coord [3];
    logic signed [COORD_W-1:0] b_coord [3];
    logic signed [COORD_W:0]   diff [3];

    always_comb
    begin
        a_coord[0] = pair.first_x;
        a_coord[1] = pair.first_y;
        a_coord[2] = pair.first_z;
        b_coord[0] = pair.second_x;
        b_coord[1] = pair.second_y;
        b_coord[2] = pair.second_z;
        for (int k = 0; k < 3; k++)
        begin
            diff[k] = (COORD_W+1)'(a_coord[k]) - (COORD_W+1)'(b_coord[k]);
            if (diff[k][COORD_W])
            begin
                absd_next[k] = ABS_W'(-diff[k]);
            end
            else
            begin
                absd_next[k] = ABS_W'(diff[k]);
            end
            sq_next[k] = SQ_W'(absd_reg[k]) * SQ_W'(absd_reg[k]);
        end
        d2_next  = D2_W'(sq_reg[0]) + D2_W'(sq_reg[1]) + D2_W'(sq_reg[2]);
        lhs_next = LHS_W'(d2_reg) * LHS_FACTOR;
    end

    always_ff @(posedge clk)
    begin
        absd_reg <= absd_next;
        sq_reg   <= sq_next;
        d2_reg   <= d2_next;
        lhs_reg  <= lhs_next;
    end

    assign lhs = lhs_reg;

endmodule

@@ design/cbpt_bound_pipe.sv @@
// ============================================================================
// Covalent bond pair test bound pipeline
// Four stages that look up the radii, check the indices and form the bond
// and search bounds; the beat's valid bit travels alongside.
// ============================================================================
module cbpt_bound_pipe
    import cbpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  cbpt_pair_t  pair,
    input  cbpt_cfg_t   cfg,
    output cbpt_bound_t bound
);

    typedef struct packed {
        logic               idx_ok;
        logic               one_h;
        logic               both_h;
        logic [RAD_W-1:0]   r1;
        logic [RAD_W-1:0]   r2;
        logic [SCALE_W-1:0] sc;
        logic [SCALE_W-1:0] m;
    } s1_t;

    typedef struct packed {
        logic               idx_ok;
        logic               one_h;
        logic               both_h;
        logic [SQR_W-1:0]   s2;
        logic [SQR_W-1:0]   rs2;
        logic [SCALE_W-1:0] sc;
        logic [MSQ_W-1:0]   m2;
    } s2_t;

    typedef struct packed {
        logic                  idx_ok;
        logic                  one_h;
        logic                  both_h;
        logic [BOND_P_W-1:0]   bond_p;
        logic [SEARCH_P_W-1:0] search_p;
    } s3_t;

    logic [3:0]  valid_reg;
    logic [3:0]  valid_next;
    s1_t         s1_reg;
    s1_t         s1_next;
    s2_t         s2_reg;
    s2_t         s2_next;
    s3_t         s3_reg;
    s3_t         s3_next;
    cbpt_bound_t s4_reg;
    cbpt_bound_t s4_next;

    logic             h1;
    logic             h2;
    logic [SUM_W-1:0] s_sum;
    logic [SUM_W-1:0] rs_sum;

    always_comb
    begin
        h1 = (pair.first_type == HYDROGEN);
        h2 = (pair.second_type == HYDROGEN);
        s1_next.both_h = h1 && h2;
        s1_next.one_h  = h1 ^ h2;
        s1_next.idx_ok = (pair.second_index < pair.first_index)
                      && (COUNT_W'(pair.first_index) < cfg.atom_count)
                      && (32'(pair.first_index) < MAX_ATOMS);
        s1_next.r1 = cov_radius(pair.first_type);
        s1_next.r2 = cov_radius(pair.second_type);
        s1_next.sc = (h1 ^ h2) ? cfg.hbond_scale : cfg.bond_scale;
        s1_next.m  = (cfg.bond_scale > cfg.hbond_scale) ? cfg.bond_scale : cfg.hbond_scale;

        s_sum  = SUM_W'(s1_reg.r1) + SUM_W'(s1_reg.r2) + TOL_UNITS;
        rs_sum = SUM_W'(s1_reg.r1) + SEARCH_UNITS;
        s2_next.idx_ok = s1_reg.idx_ok;
        s2_next.one_h  = s1_reg.one_h;
        s2_next.both_h = s1_reg.both_h;
        s2_next.s2     = SQR_W'(s_sum) * SQR_W'(s_sum);
        s2_next.rs2    = SQR_W'(rs_sum) * SQR_W'(rs_sum);
        s2_next.sc     = s1_reg.sc;
        s2_next.m2     = MSQ_W'(s1_reg.m) * MSQ_W'(s1_reg.m);

        s3_next.idx_ok   = s2_reg.idx_ok;
        s3_next.one_h    = s2_reg.one_h;
        s3_next.both_h   = s2_reg.both_h;
        s3_next.bond_p   = BOND_P_W'(s2_reg.s2) * BOND_P_W'(s2_reg.sc);
        s3_next.search_p = SEARCH_P_W'(s2_reg.rs2) * SEARCH_P_W'(s2_reg.m2);

        s4_next.valid      = valid_reg[2];
        s4_next.idx_ok     = s3_reg.idx_ok;
        s4_next.one_h      = s3_reg.one_h;
        s4_next.both_h     = s3_reg.both_h;
        s4_next.bond_rhs   = {s3_reg.bond_p, {BOND_SHIFT{1'b0}}};
        s4_next.search_rhs = {s3_reg.search_p, {SEARCH_SHIFT{1'b0}}};

        valid_next = {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        s3_reg <= s3_next;
        s4_reg <= s4_next;
    end

    always_comb
    begin
        bound       = s4_reg;
        bound.valid = valid_reg[3];
    end

endmodule

@@ design/covalent_bond_pair_test_core.sv @@
// ============================================================================
// Covalent bond pair test core
// Decides whether one candidate atom pair forms a covalent bond and whether
// it lies within the neighbor search radius.
//
//   Channel   Signals                          Beat taken when
//   -------   ------------------------------   ------------------------
//   pair      start, busy, pair                start high, busy low
//   result    done, result                     done high (one cycle)
//   config    wr_en, wr_index, wr_data         wr_en high
//
// One pair enters every cycle; busy stays low.
// Each taken pair passes four compute stages and then the output register.
// Reset clears the valid bits and loads the register defaults; no beat is
// in flight after reset. The receiver cannot stall, so nothing is held.
// ============================================================================
module covalent_bond_pair_test_core
    import cbpt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  cbpt_pair_t         pair,
    output logic               done,
    output cbpt_result_t       result,
    input  logic               wr_en,
    input  logic [WIDX_W-1:0]  wr_index,
    input  logic [WDATA_W-1:0] wr_data
);

    cbpt_cfg_t        cfg;
    cbpt_bound_t      bound;
    logic [LHS_W-1:0] lhs;
    logic             accept;

    logic         done_reg;
    logic         done_next;
    cbpt_result_t result_reg;
    cbpt_result_t result_next;

    logic close;
    logic in_search;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    cbpt_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    cbpt_dist_pipe u_dist_pipe (
        .clk  (clk),
        .pair (pair),
        .lhs  (lhs)
    );

    cbpt_bound_pipe u_bound_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .pair     (pair),
        .cfg      (cfg),
        .bound    (bound)
    );

    always_comb
    begin
        close     = (lhs <= LHS_W'(bound.bond_rhs));
        in_search = (lhs <= LHS_W'(bound.search_rhs));
        done_next = bound.valid;
        result_next.is_bond             = bound.idx_ok && !bound.both_h && close && in_search;
        result_next.used_hydrogen_scale = bound.one_h;
        result_next.in_search_radius    = in_search;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ design/cbpt_checker.sv @@
// ============================================================================
// Covalent bond pair test checker
// Watches the core's ports for beat latency and bond preconditions.
// ============================================================================
`include "covalent_bond_pair_test_core_assert.svh"

module cbpt_checker
    import cbpt_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input cbpt_pair_t   pair,
    input logic         done,
    input cbpt_result_t result
);

    logic [2:0] warm_cnt_reg;
    logic [2:0] warm_cnt_next;
    logic       warm;

    assign warm = (warm_cnt_reg == 3'(PIPE_LATENCY));

    always_comb
    begin
        warm_cnt_next = warm ? warm_cnt_reg : warm_cnt_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_cnt_reg <= '0;
        end
        else
        begin
            warm_cnt_reg <= warm_cnt_next;
        end
    end

    `CBPT_ASSERT_IMP(a_done_follows_beat, clk, rst_n, warm && done, $past(start && !busy, PIPE_LATENCY))
    `CBPT_ASSERT_IMP(a_beat_gives_done, clk, rst_n, warm && $past(start && !busy, PIPE_LATENCY), done)
    `CBPT_ASSERT_IMP(a_bond_index_order, clk, rst_n, warm && done && result.is_bond, $past(pair.second_index < pair.first_index, PIPE_LATENCY))
    `CBPT_ASSERT_IMP(a_bond_not_two_h, clk, rst_n, warm && done && result.is_bond, $past(pair.first_type != HYDROGEN || pair.second_type != HYDROGEN, PIPE_LATENCY))

endmodule

bind covalent_bond_pair_test_core cbpt_checker u_cbpt_checker (.*);

@@ verif/covalent_bond_pair_test_core_tb.sv @@
// ============================================================================
// Covalent bond pair test core testbench
// Drives candidate atom pairs into the core one beat at a time and checks
// every result beat against an in-bench prediction of the bond, hydrogen
// scale and search radius decisions. It runs a directed set of boundary
// pairs first, then random phases under changing scale and atom count
// settings. The settings are written only while no beat is in flight.
// ============================================================================
module covalent_bond_pair_test_core_tb
    import cbpt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD  = 10;
    localparam int          STALL_LIMIT = 200;
    localparam int          ROM_LEN     = 103;
    localparam int unsigned TOL_SPAN    = 140;
    localparam int unsigned SEARCH_SPAN = 640;
    localparam int          C_MAX       = 8388607;
    localparam int          C_MIN       = -8388608;

    localparam logic [WIDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [TYPE_W-1:0] T_H    = 7'd0;
    localparam logic [TYPE_W-1:0] T_N    = 7'd6;
    localparam logic [TYPE_W-1:0] T_LAST = 7'd102;
    localparam logic [TYPE_W-1:0] T_OFF  = 7'd103;
    localparam logic [TYPE_W-1:0] T_TOP  = 7'd127;

    localparam int unsigned COV_RADII [ROM_LEN] = '{
        80, 400, 170, 88, 208, 180, 170, 170, 160, 280,
        243, 275, 338, 300, 259, 255, 250, 392, 332, 248,
        360, 368, 332, 338, 338, 335, 332, 405, 380, 362,
        305, 292, 302, 305, 302, 400, 368, 280, 445, 390,
        370, 368, 338, 350, 362, 375, 398, 422, 408, 365,
        365, 368, 350, 425, 418, 335, 468, 458, 455, 452,
        450, 450, 498, 448, 440, 438, 435, 432, 430, 485,
        430, 392, 358, 342, 338, 342, 330, 375, 375, 425,
        388, 385, 385, 420, 302, 475, 450, 358, 295, 255,
        222, 242, 238, 232, 230, 228, 225, 222, 220, 218,
        215, 212, 210
    };

    class bond_verdicts;
        longint unsigned bond_scale;
        longint unsigned hbond_scale;
        longint unsigned atom_count;
        cbpt_result_t    pending [$];
        int unsigned     fail_count;
        int unsigned     checked_count;

        function new();
            bond_scale    = 256;
            hbond_scale   = 256;
            atom_count    = 0;
            fail_count    = 0;
            checked_count = 0;
        endfunction

        function void write_reg(input logic [WIDX_W-1:0] idx, input logic [WDATA_W-1:0] val);
            case (idx)
                REG_BOND_SCALE:  bond_scale  = val[SCALE_W-1:0];
                REG_HBOND_SCALE: hbond_scale = val[SCALE_W-1:0];
                REG_ATOM_COUNT:  atom_count  = val[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned radius(input logic [TYPE_W-1:0] t);
            if (int'(t) >= ELEMENT_TYPES || int'(t) >= ROM_LEN)
            begin
                return 0;
            end
            return COV_RADII[t];
        endfunction

        function longint unsigned axis_square(input logic signed [COORD_W-1:0] a,
                                              input logic signed [COORD_W-1:0] b);
            longint d;
            d = longint'(a) - longint'(b);
            if (d < 0)
            begin
                d = -d;
            end
            return longint'(unsigned'(d)) * longint'(unsigned'(d));
        endfunction

        function cbpt_result_t predict_verdict(input cbpt_pair_t p);
            longint unsigned r1, r2, d2, lhs, m, rs, s, sc;
            bit              h1, h2, both_h, one_h, in_search, close, idx_ok;
            cbpt_result_t    res;
            r1 = radius(p.first_type);
            r2 = radius(p.second_type);
            d2 = axis_square(p.first_x, p.second_x) + axis_square(p.first_y, p.second_y)
                 + axis_square(p.first_z, p.second_z);
            lhs = d2 * 64'd15625;
            h1 = (p.first_type == T_H);
            h2 = (p.second_type == T_H);
            both_h = h1 && h2;
            one_h  = (h1 || h2) && !both_h;
            m  = (bond_scale > hbond_scale) ? bond_scale : hbond_scale;
            rs = r1 + SEARCH_SPAN;
            in_search = (lhs <= rs * rs * m * m * 64'd4);
            s  = r1 + r2 + TOL_SPAN;
            sc = one_h ? hbond_scale : bond_scale;
            close = (lhs <= s * s * sc * 64'd1024);
            idx_ok = (p.second_index < p.first_index) && (p.first_index < atom_count)
                     && (p.first_index < MAX_ATOMS);
            res.is_bond             = idx_ok && !both_h && close && in_search;
            res.used_hydrogen_scale = one_h;
            res.in_search_radius    = in_search;
            return res;
        endfunction

        function void note_failure(input string msg);
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("%s", msg);
            end
        endfunction

        function void accept_pair(input cbpt_pair_t p);
            pending.push_back(predict_verdict(p));
        endfunction

        function void check_result(input cbpt_result_t got);
            cbpt_result_t want;
            checked_count++;
            if (pending.size() == 0)
            begin
                note_failure($sformatf("result beat %0d arrived with none due: %b",
                                       checked_count, got));
                return;
            end
            want = pending.pop_front();
            if (got.is_bond !== want.is_bond
                || got.used_hydrogen_scale !== want.used_hydrogen_scale
                || got.in_search_radius !== want.in_search_radius)
            begin
                note_failure($sformatf(
                    "result beat %0d: expected bond=%b hscale=%b search=%b, got bond=%b hscale=%b search=%b",
                    checked_count, want.is_bond, want.used_hydrogen_scale,
                    want.in_search_radius, got.is_bond, got.used_hydrogen_scale,
                    got.in_search_radius));
            end
        endfunction
    endclass

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               start    = 1'b0;
    logic               busy;
    cbpt_pair_t         pair     = '0;
    logic               done;
    cbpt_result_t       result;
    logic               wr_en    = 1'b0;
    logic [WIDX_W-1:0]  wr_index = '0;
    logic [WDATA_W-1:0] wr_data  = '0;

    bond_verdicts verdicts;
    int unsigned  stall_cycles = 0;

    covalent_bond_pair_test_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .pair     (pair),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            verdicts.check_result(result);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic cbpt_pair_t atom_pair(
        input int unsigned fi, input logic [TYPE_W-1:0] ft, input int fx, input int fy,
        input int fz, input int unsigned si, input logic [TYPE_W-1:0] st, input int sx,
        input int sy, input int sz);
        cbpt_pair_t p;
        p.first_index  = INDEX_W'(fi);
        p.first_type   = ft;
        p.first_x      = COORD_W'(fx);
        p.first_y      = COORD_W'(fy);
        p.first_z      = COORD_W'(fz);
        p.second_index = INDEX_W'(si);
        p.second_type  = st;
        p.second_x     = COORD_W'(sx);
        p.second_y     = COORD_W'(sy);
        p.second_z     = COORD_W'(sz);
        return p;
    endfunction

    function automatic int unsigned idle_gap();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom_range(1, 4);
        end
        return 0;
    endfunction

    function automatic int unsigned draw_scale();
        if ($urandom_range(0, 1) == 1)
        begin
            return $urandom_range(64, 1024);
        end
        return $urandom_range(0, 65535);
    endfunction

    function automatic logic [TYPE_W-1:0] draw_element();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 25)
        begin
            return T_H;
        end
        else if (k < 85)
        begin
            return TYPE_W'($urandom_range(1, 102));
        end
        return TYPE_W'($urandom_range(103, 127));
    endfunction

    function automatic cbpt_pair_t random_candidate();
        cbpt_pair_t      p;
        int unsigned     kind, top, sc, m;
        longint unsigned r1, r2;
        bit              one_h;
        real             reach;
        int              lim, span, bx, by, bz;
        kind = $urandom_range(0, 99);
        p.first_type  = draw_element();
        p.second_type = draw_element();
        if (kind < 75 && verdicts.atom_count >= 2)
        begin
            top = int'(verdicts.atom_count) - 1;
            if (top > 65535)
            begin
                top = 65535;
            end
            p.first_index  = INDEX_W'($urandom_range(1, top));
            p.second_index = INDEX_W'($urandom_range(0, p.first_index - 1));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    p.first_index  = INDEX_W'($urandom);
                    p.second_index = INDEX_W'($urandom);
                end
                1:
                begin
                    p.first_index  = INDEX_W'($urandom);
                    p.second_index = p.first_index;
                end
                2:
                begin
                    p.first_index  = INDEX_W'($urandom);
                    p.second_index = INDEX_W'(p.first_index
                                     + $urandom_range(0, 65535 - p.first_index));
                end
                default:
                begin
                    p.first_index  = INDEX_W'(verdicts.atom_count + $urandom_range(0, 3));
                    p.second_index = INDEX_W'($urandom);
                end
            endcase
        end
        r1 = verdicts.radius(p.first_type);
        r2 = verdicts.radius(p.second_type);
        one_h = (p.first_type == T_H) != (p.second_type == T_H);
        sc = int'(one_h ? verdicts.hbond_scale : verdicts.bond_scale);
        m  = int'((verdicts.bond_scale > verdicts.hbond_scale)
                  ? verdicts.bond_scale : verdicts.hbond_scale);
        if ($urandom_range(0, 1) == 1)
        begin
            reach = real'(r1 + r2 + TOL_SPAN) * 4.096 * $sqrt(real'(sc) / 256.0);
        end
        else
        begin
            reach = real'(r1 + SEARCH_SPAN) * real'(m) / 62.5;
        end
        lim = int'(reach * real'($urandom_range(20, 120)) / 100.0);
        if (kind >= 85)
        begin
            p.first_x  = COORD_W'($urandom);
            p.first_y  = COORD_W'($urandom);
            p.first_z  = COORD_W'($urandom);
            p.second_x = COORD_W'($urandom);
            p.second_y = COORD_W'($urandom);
            p.second_z = COORD_W'($urandom);
        end
        else
        begin
            if (kind % 10 == 0)
            begin
                lim = 0;
            end
            span = C_MAX - lim;
            bx = int'($urandom_range(0, 2 * span)) - span;
            by = int'($urandom_range(0, 2 * span)) - span;
            bz = int'($urandom_range(0, 2 * span)) - span;
            p.first_x  = COORD_W'(bx);
            p.first_y  = COORD_W'(by);
            p.first_z  = COORD_W'(bz);
            p.second_x = COORD_W'(bx + int'($urandom_range(0, 2 * lim)) - lim);
            p.second_y = COORD_W'(by + int'($urandom_range(0, 2 * lim)) - lim);
            p.second_z = COORD_W'(bz + int'($urandom_range(0, 2 * lim)) - lim);
        end
        return p;
    endfunction

    task automatic send_pair(input cbpt_pair_t p, input int unsigned gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        pair  <= p;
        do
            @(posedge clk);
        while (busy);
        verdicts.accept_pair(p);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (verdicts.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic load_settings(input int unsigned bond, input int unsigned hbond,
                                 input int unsigned count);
        logic [WIDX_W-1:0]  idx [4];
        logic [WDATA_W-1:0] val [4];
        idx[0] = REG_BOND_SCALE;
        idx[1] = REG_UNUSED;
        idx[2] = REG_HBOND_SCALE;
        idx[3] = REG_ATOM_COUNT;
        val[0] = {1'($urandom), SCALE_W'(bond)};
        val[1] = WDATA_W'($urandom);
        val[2] = {1'($urandom), SCALE_W'(hbond)};
        val[3] = COUNT_W'(count);
        wr_en <= 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            wr_index <= idx[k];
            wr_data  <= val[k];
            @(posedge clk);
            verdicts.write_reg(idx[k], val[k]);
        end
        wr_en <= 1'b0;
    endtask

    task automatic run_random(input int unsigned items, input bit idle);
        cbpt_pair_t  p;
        int unsigned gap;
        for (int unsigned n = 0; n < items; n++)
        begin
            p = random_candidate();
            gap = 0;
            if (idle && (n % 64) >= 16)
            begin
                gap = idle_gap();
            end
            send_pair(p, gap);
        end
    endtask

    initial
    begin
        cbpt_pair_t plan [$];
        verdicts = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: no atoms are loaded, so a close pair does not bond.
        send_pair(atom_pair(1, T_N, 0, 0, 0, 0, T_N, 0, 0, 0), 0);
        settle();

        load_settings(256, 256, 65536);
        plan.push_back(atom_pair(1, T_H, 0, 0, 0, 0, T_H, 0, 0, 0));
        plan.push_back(atom_pair(5, T_H, 0, 0, 0, 2, T_N, 100, 0, 0));
        plan.push_back(atom_pair(5, T_N, 0, 0, 0, 2, T_H, 0, 100, 0));
        plan.push_back(atom_pair(9, T_N, 0, 0, 0, 4, T_N, 1966, 0, 0));
        plan.push_back(atom_pair(9, T_N, 0, 0, 0, 4, T_N, 1967, 0, 0));
        plan.push_back(atom_pair(9, T_N, 0, 0, 0, 4, T_N, 0, 3317, 0));
        plan.push_back(atom_pair(9, T_N, 0, 0, 0, 4, T_N, 0, 0, 3318));
        plan.push_back(atom_pair(7, T_N, 10, 10, 10, 7, T_N, 10, 10, 10));
        plan.push_back(atom_pair(3, T_N, 10, 10, 10, 9, T_N, 10, 10, 10));
        plan.push_back(atom_pair(65535, T_N, -5, 7, 9, 0, T_N, -5, 7, 9));
        plan.push_back(atom_pair(20, T_LAST, 0, 0, 0, 10, T_LAST, 0, 0, 0));
        plan.push_back(atom_pair(20, T_OFF, 0, 0, 0, 10, T_TOP, 0, 0, 0));
        plan.push_back(atom_pair(20, T_TOP, 0, 0, 0, 10, T_H, 50, 0, 0));
        plan.push_back(atom_pair(65535, T_TOP, C_MAX, C_MAX, C_MAX,
                                 65534, T_TOP, C_MIN, C_MIN, C_MIN));
        plan.push_back(atom_pair(65535, T_N, C_MIN, C_MIN, C_MIN,
                                 65534, T_N, C_MAX, C_MAX, C_MAX));
        plan.push_back(atom_pair(100, T_N, C_MAX, C_MAX, C_MAX, 99, T_N, C_MAX, C_MAX, C_MAX));
        plan.push_back(atom_pair(65535, T_N, 0, 0, 0, 65535, T_N, 0, 0, 0));
        foreach (plan[k])
        begin
            send_pair(plan[k], idle_gap());
        end
        settle();

        // Zero scales: only coincident atoms stay within the bound.
        load_settings(0, 0, 65536);
        send_pair(atom_pair(8, T_N, 4, 4, 4, 3, T_N, 4, 4, 4), 0);
        send_pair(atom_pair(8, T_N, 4, 4, 4, 3, T_N, 5, 4, 4), idle_gap());
        send_pair(atom_pair(8, T_H, 4, 4, 4, 3, T_N, 4, 4, 4), idle_gap());
        settle();

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: load_settings(256, 256, 65536);
                1: load_settings(0, 65535, 1000);
                2: load_settings(65535, 0, 65535);
                3: load_settings(65535, 65535, 65536);
                4: load_settings(0, 0, 2);
                5: load_settings(draw_scale(), draw_scale(), 0);
                default: load_settings(draw_scale(), draw_scale(), $urandom_range(2, 65536));
            endcase
            run_random(155, ph != 9);
            settle();
        end

        if (verdicts.pending.size() != 0)
        begin
            verdicts.note_failure($sformatf("%0d result beats never arrived",
                                            verdicts.pending.size()));
        end
        if (verdicts.fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/cbpt_pkg.sv
design/cbpt_cfg_regs.sv
design/cbpt_dist_pipe.sv
design/cbpt_bound_pipe.sv
design/covalent_bond_pair_test_core.sv
design/cbpt_checker.sv
verif/covalent_bond_pair_test_core_tb.sv
